### sv/rcj_pkg.sv
// shared types, constants and helpers for the rc joystick accumulator rotator
package rcj_pkg;

    // configuration port geometry
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register indexes
    localparam logic [1:0] REG_ROUTE_ENABLE     = 2'd0;
    localparam logic [1:0] REG_CHANNELS_PRESENT = 2'd1;
    localparam logic [1:0] REG_VECTOR_MIN       = 2'd2;
    localparam logic [1:0] REG_VECTOR_MAX       = 2'd3;

    // register reset values
    localparam logic               RST_ROUTE_ENABLE     = 1'b0;
    localparam logic               RST_CHANNELS_PRESENT = 1'b1;
    localparam logic signed [15:0] RST_VECTOR_MIN       = -16'sd1000;
    localparam logic [14:0]        RST_VECTOR_MAX       = 15'd1000;

    // status codes
    localparam logic [1:0] ST_APPLIED     = 2'd0;
    localparam logic [1:0] ST_NOT_ROUTED  = 2'd1;
    localparam logic [1:0] ST_NO_CHANNELS = 2'd2;

    // command codes
    localparam logic CMD_MOVE = 1'b0;
    localparam logic CMD_ABS  = 1'b1;

    // 45 degree rotation: floor(707 * m / 1000) by reciprocal with one correction
    localparam int ROT_MAG_W = 17;
    localparam int ROT_N_W   = 26;
    localparam int ROT_RW    = 17;
    localparam int ROT_P_W   = ROT_N_W + ROT_RW;
    localparam logic [9:0]         ROT_NUM   = 10'd707;
    localparam logic [ROT_N_W-1:0] ROT_DEN   = ROT_N_W'(1000);
    localparam logic [ROT_RW-1:0]  ROT_RECIP = ROT_RW'((64'd1 << ROT_N_W) / 64'd1000);

    typedef struct packed {
        logic               route_enable;
        logic               channels_present;
        logic signed [15:0] vector_min;
        logic [14:0]        vector_max;
    } cfg_t;

    // request between front and back, already classified
    typedef struct packed {
        logic [1:0]         status;
        logic               command;
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic [31:0]        time_ms;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
    } result_t;

    // raise to lo, then lower to hi
    function automatic logic signed [15:0] clamp_axis(
        input logic signed [31:0] v,
        input logic signed [15:0] lo,
        input logic [14:0]        hi
    );
        logic signed [31:0] t;
        logic signed [31:0] lo_w;
        logic signed [31:0] hi_w;
        lo_w = 32'(lo);
        hi_w = {17'd0, hi};
        t = v;
        if (t < lo_w)
        begin
            t = lo_w;
        end
        if (t > hi_w)
        begin
            t = hi_w;
        end
        return t[15:0];
    endfunction

endpackage

### sv/rcj_queue.sv
// two-entry queue used between the block's parts
module rcj_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);
    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] cnt_next;
    logic          do_push;
    logic          do_pop;

    // flags and head
    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### sv/rcj_regs.sv
// configuration registers behind the apb port
module rcj_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rcj_pkg::APB_AW-1:0]   paddr,
    input  logic [rcj_pkg::APB_DW-1:0]   pwdata,
    output logic [rcj_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output rcj_pkg::cfg_t                cfg
);
    import rcj_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ROUTE_ENABLE:     cfg_next.route_enable     = pwdata[0];
                REG_CHANNELS_PRESENT: cfg_next.channels_present = pwdata[0];
                REG_VECTOR_MIN:       cfg_next.vector_min       = pwdata[15:0];
                REG_VECTOR_MAX:       cfg_next.vector_max       = pwdata[14:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.route_enable     <= RST_ROUTE_ENABLE;
            cfg_reg.channels_present <= RST_CHANNELS_PRESENT;
            cfg_reg.vector_min       <= RST_VECTOR_MIN;
            cfg_reg.vector_max       <= RST_VECTOR_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_ROUTE_ENABLE:     prdata = {31'd0, cfg_reg.route_enable};
            REG_CHANNELS_PRESENT: prdata = {31'd0, cfg_reg.channels_present};
            REG_VECTOR_MIN:       prdata = {{16{cfg_reg.vector_min[15]}}, cfg_reg.vector_min};
            REG_VECTOR_MAX:       prdata = {17'd0, cfg_reg.vector_max};
            default:              prdata = '0;
        endcase
    end

endmodule

### sv/rcj_front.sv
// front end: accepts pointer events and classifies them
module rcj_front (
    input  logic               push,
    output logic               full,
    input  logic               command,
    input  logic signed [15:0] x_value,
    input  logic signed [15:0] y_value,
    input  logic [31:0]        time_ms,
    input  rcj_pkg::cfg_t      cfg,
    input  logic               q_full,
    output logic               q_push,
    output rcj_pkg::item_t     q_item
);
    import rcj_pkg::*;

    assign full   = q_full;
    assign q_push = push && !q_full;

    // refusal checks, channel check first
    always_comb
    begin
        q_item.command = command;
        q_item.x_value = x_value;
        q_item.y_value = y_value;
        q_item.time_ms = time_ms;
        if (!cfg.channels_present)
        begin
            q_item.status = ST_NO_CHANNELS;
        end
        else if ((command == CMD_MOVE) && !cfg.route_enable)
        begin
            q_item.status = ST_NOT_ROUTED;
        end
        else
        begin
            q_item.status = ST_APPLIED;
        end
    end

endmodule

### sv/rcj_back.sv
// back end: decay, accumulate, rotate and clamp sequencer
module rcj_back #(
    parameter int GAIN              = 3,
    parameter int DECAY_INTERVAL_MS = 50,
    parameter int DECAY_AMOUNT      = 30
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rcj_pkg::cfg_t    cfg,
    input  rcj_pkg::item_t   in_item,
    input  logic             in_empty,
    output logic             in_pop,
    input  logic             out_full,
    output logic             out_push,
    output rcj_pkg::result_t out_res
);
    import rcj_pkg::*;

    // decay quotient bounds: any quotient from QMAX up clears an axis
    localparam int     QMAX    = 32768 / DECAY_AMOUNT + 1;
    localparam longint SAT_LIM = longint'(QMAX) * DECAY_INTERVAL_MS;
    localparam int     EW      = $clog2(SAT_LIM);
    localparam int     RW      = EW + 1;
    localparam int     QW      = $clog2(QMAX + 1);
    localparam int     AW      = $clog2(longint'(QMAX) * DECAY_AMOUNT + 1);
    localparam int     GXW     = 16 + $clog2(GAIN + 1);
    localparam longint RECIP   = (longint'(1) << EW) / DECAY_INTERVAL_MS;

    localparam logic [31:0]           SAT_LIM_V = 32'(SAT_LIM);
    localparam logic [RW-1:0]         RECIP_V   = RW'(RECIP);
    localparam logic [EW-1:0]         DI_V      = EW'(DECAY_INTERVAL_MS);
    localparam logic [QW-1:0]         QMAX_V    = QW'(QMAX);
    localparam logic [AW-1:0]         DA_V      = AW'(DECAY_AMOUNT);
    localparam logic signed [GXW-1:0] GAIN_V    = GXW'(GAIN);

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC1 = 4'd1;
    localparam logic [3:0] S_DEC2 = 4'd2;
    localparam logic [3:0] S_DEC3 = 4'd3;
    localparam logic [3:0] S_ACC  = 4'd4;
    localparam logic [3:0] S_ROT1 = 4'd5;
    localparam logic [3:0] S_ROT2 = 4'd6;
    localparam logic [3:0] S_ROT3 = 4'd7;
    localparam logic [3:0] S_ROT4 = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    // saturating decay of one axis toward zero
    function automatic logic signed [15:0] decay_axis(
        input logic signed [15:0] a,
        input logic [AW-1:0]      amt
    );
        logic signed [17:0] aw;
        logic signed [17:0] amt_w;
        logic [16:0]        mag;
        logic signed [17:0] res;
        aw    = 18'(a);
        amt_w = 18'(amt);
        mag   = a[15] ? 17'(-aw) : 17'(aw);
        res   = a[15] ? (aw + amt_w) : (aw - amt_w);
        if (mag > 17'(amt))
        begin
            return res[15:0];
        end
        return 16'sd0;
    endfunction

    // control state
    logic [3:0]         state_reg;
    logic [3:0]         state_next;
    logic signed [15:0] acc_x_reg;
    logic signed [15:0] acc_y_reg;
    logic [31:0]        last_time_reg;
    logic signed [15:0] acc_x_next;
    logic signed [15:0] acc_y_next;
    logic [31:0]        last_time_next;

    // payload pipeline registers
    item_t                 item_reg;
    logic [EW-1:0]         e_reg;
    logic                  sat_reg;
    logic [EW+RW-1:0]      prod_reg;
    logic [QW-1:0]         q0_reg;
    logic [EW-1:0]         chk_reg;
    logic [AW-1:0]         amt_reg;
    logic signed [GXW-1:0] gx_reg;
    logic signed [GXW-1:0] gy_reg;
    logic signed [15:0]    vx_reg;
    logic signed [15:0]    vy_reg;
    logic [1:0]            neg_reg;
    logic [ROT_N_W-1:0]    n_reg    [2];
    logic [ROT_P_W-1:0]    rp_reg   [2];
    logic [ROT_MAG_W-1:0]  rq0_reg  [2];
    logic [ROT_N_W-1:0]    rchk_reg [2];
    result_t               res_reg;

    // combinational helpers
    logic [31:0]           elapsed;
    logic                  sat;
    logic [EW-1:0]         e_clip;
    logic [QW-1:0]         q0;
    logic [EW-1:0]         rem;
    logic [QW-1:0]         q_sel;
    logic signed [15:0]    dec_x;
    logic signed [15:0]    dec_y;
    logic signed [31:0]    sum_x;
    logic signed [31:0]    sum_y;
    logic signed [16:0]    rot_s [2];
    logic [ROT_MAG_W-1:0]  rot_m [2];
    logic [ROT_N_W-1:0]    rot_r [2];
    logic [ROT_MAG_W-1:0]  rot_q [2];
    logic signed [31:0]    rot_w [2];
    logic signed [31:0]    rot_v [2];

    assign in_pop   = (state_reg == S_IDLE) && !in_empty;
    assign out_push = (state_reg == S_DONE) && !out_full;
    assign out_res  = res_reg;

    // elapsed time, clipped where the decay surely clears both axes
    assign elapsed = item_reg.time_ms - last_time_reg;
    assign sat     = (elapsed >= SAT_LIM_V);
    assign e_clip  = sat ? '0 : elapsed[EW-1:0];

    // quotient correction
    assign q0    = prod_reg[EW +: QW];
    assign rem   = e_reg - chk_reg;
    assign q_sel = sat_reg ? QMAX_V : (q0_reg + QW'(rem >= DI_V));

    // decay, add scaled delta, clamp
    assign dec_x = decay_axis(acc_x_reg, amt_reg);
    assign dec_y = decay_axis(acc_y_reg, amt_reg);
    assign sum_x = 32'(dec_x) + 32'(gx_reg);
    assign sum_y = 32'(dec_y) + 32'(gy_reg);

    // rotation lanes: lane 0 is x+y, lane 1 is y-x
    always_comb
    begin
        rot_s[0] = 17'(vx_reg) + 17'(vy_reg);
        rot_s[1] = 17'(vy_reg) - 17'(vx_reg);
        for (int i = 0; i < 2; i++)
        begin
            rot_m[i] = rot_s[i][16] ? 17'(-rot_s[i]) : 17'(rot_s[i]);
            rot_r[i] = n_reg[i] - rchk_reg[i];
            rot_q[i] = rq0_reg[i] + ROT_MAG_W'(rot_r[i] >= ROT_DEN);
            rot_w[i] = {15'd0, rot_q[i]};
            rot_v[i] = neg_reg[i] ? -rot_w[i] : rot_w[i];
        end
    end

    // sequencer and accumulator state
    always_comb
    begin
        state_next     = state_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        last_time_next = last_time_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!in_empty)
                begin
                    if (in_item.status != ST_APPLIED)
                    begin
                        state_next = S_DONE;
                    end
                    else if (in_item.command == CMD_MOVE)
                    begin
                        state_next = S_DEC1;
                    end
                    else
                    begin
                        state_next = S_ROT1;
                    end
                end
            end
            S_DEC1: state_next = S_DEC2;
            S_DEC2: state_next = S_DEC3;
            S_DEC3: state_next = S_ACC;
            S_ACC:
            begin
                acc_x_next     = clamp_axis(sum_x, cfg.vector_min, cfg.vector_max);
                acc_y_next     = clamp_axis(sum_y, cfg.vector_min, cfg.vector_max);
                last_time_next = item_reg.time_ms;
                state_next     = S_ROT1;
            end
            S_ROT1: state_next = S_ROT2;
            S_ROT2: state_next = S_ROT3;
            S_ROT3: state_next = S_ROT4;
            S_ROT4: state_next = S_DONE;
            S_DONE:
            begin
                if (!out_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            last_time_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            last_time_reg <= last_time_next;
        end
    end

    // datapath registers, loaded per sequencer step
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                item_reg        <= in_item;
                vx_reg          <= in_item.x_value;
                vy_reg          <= in_item.y_value;
                res_reg.status  <= in_item.status;
                res_reg.out_x   <= '0;
                res_reg.out_y   <= '0;
            end
            S_DEC1:
            begin
                e_reg    <= e_clip;
                sat_reg  <= sat;
                prod_reg <= (EW+RW)'(e_clip) * (EW+RW)'(RECIP_V);
                gx_reg   <= GXW'(item_reg.x_value) * GAIN_V;
                gy_reg   <= GXW'(item_reg.y_value) * GAIN_V;
            end
            S_DEC2:
            begin
                q0_reg  <= q0;
                chk_reg <= EW'(q0) * DI_V;
            end
            S_DEC3:
            begin
                amt_reg <= AW'(q_sel) * DA_V;
            end
            S_ACC:
            begin
                vx_reg <= acc_x_next;
                vy_reg <= acc_y_next;
            end
            S_ROT1:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    n_reg[i]   <= ROT_N_W'(rot_m[i]) * ROT_N_W'(ROT_NUM);
                    neg_reg[i] <= rot_s[i][16];
                end
            end
            S_ROT2:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    rp_reg[i] <= ROT_P_W'(n_reg[i]) * ROT_P_W'(ROT_RECIP);
                end
            end
            S_ROT3:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    rq0_reg[i]  <= rp_reg[i][ROT_P_W-1:ROT_N_W];
                    rchk_reg[i] <= ROT_N_W'(rp_reg[i][ROT_P_W-1:ROT_N_W]) * ROT_DEN;
                end
            end
            S_ROT4:
            begin
                res_reg.status <= ST_APPLIED;
                res_reg.out_x  <= clamp_axis(rot_v[0], cfg.vector_min, cfg.vector_max);
                res_reg.out_y  <= clamp_axis(rot_v[1], cfg.vector_min, cfg.vector_max);
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

endmodule

### sv/rc_joystick_accumulator_rotator_unit.sv
// top level of the rc joystick accumulator rotator
//
// Pointer events enter through a queue-style port: an event is taken on a
// clock edge with push high and full low. Results leave the same way: the
// oldest result sits on status/out_x/out_y while empty is low and is taken
// on an edge with pop high. One result comes out per event, in order.
// A relative move decays, accumulates and clamps the stored axes, then the
// vector is rotated by 45 degrees and clamped; an absolute event is rotated
// directly. Refused events give status 1 or 2 with zero axes.
// A two-entry queue sits between the classifying front end and the
// sequencer, and another holds finished results. When the receiver stalls,
// results wait in the result queue; once it is full the sequencer holds and
// full rises as soon as the request queue has filled behind it.
// The sequencer handles one event at a time. A relative move steps
// through load (S_IDLE), the decay quotient (S_DEC1 to S_DEC3),
// accumulate (S_ACC), the rotation multiplies (S_ROT1 to S_ROT4) and
// hand-off (S_DONE); an absolute event skips the decay and accumulate
// states, and a refused event goes from load straight to hand-off.
// Reset clears the queues, the accumulator and the last move time and
// returns the registers to their defaults; no clearing pass is needed.
module rc_joystick_accumulator_rotator_unit #(
    parameter int GAIN              = 3,
    parameter int DECAY_INTERVAL_MS = 50,
    parameter int DECAY_AMOUNT      = 30
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rcj_pkg::APB_AW-1:0]  paddr,
    input  logic [rcj_pkg::APB_DW-1:0]  pwdata,
    output logic [rcj_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  logic                        command,
    input  logic signed [15:0]          x_value,
    input  logic signed [15:0]          y_value,
    input  logic [31:0]                 time_ms,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  status,
    output logic signed [15:0]          out_x,
    output logic signed [15:0]          out_y
);
    import rcj_pkg::*;

    localparam int IW = $bits(item_t);
    localparam int RSW = $bits(result_t);

    cfg_t           cfg;
    logic           cq_full;
    logic           cq_push;
    item_t          cq_wr_item;
    logic [IW-1:0]  cq_rdata;
    item_t          cq_head;
    logic           cq_empty;
    logic           cq_pop;
    logic           rq_full;
    logic           rq_push;
    result_t        rq_wr_res;
    logic [RSW-1:0] rq_rdata;
    result_t        rq_head;

    // configuration registers
    rcj_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // front end classification
    rcj_front u_front (
        .push     (push),
        .full     (full),
        .command  (command),
        .x_value  (x_value),
        .y_value  (y_value),
        .time_ms  (time_ms),
        .cfg      (cfg),
        .q_full   (cq_full),
        .q_push   (cq_push),
        .q_item   (cq_wr_item)
    );

    // request queue between front and back
    rcj_queue #(
        .W (IW)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .wdata (cq_wr_item),
        .full  (cq_full),
        .pop   (cq_pop),
        .rdata (cq_rdata),
        .empty (cq_empty)
    );

    assign cq_head = item_t'(cq_rdata);

    // back end sequencer
    rcj_back #(
        .GAIN              (GAIN),
        .DECAY_INTERVAL_MS (DECAY_INTERVAL_MS),
        .DECAY_AMOUNT      (DECAY_AMOUNT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_item  (cq_head),
        .in_empty (cq_empty),
        .in_pop   (cq_pop),
        .out_full (rq_full),
        .out_push (rq_push),
        .out_res  (rq_wr_res)
    );

    // result queue
    rcj_queue #(
        .W (RSW)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .wdata (rq_wr_res),
        .full  (rq_full),
        .pop   (pop),
        .rdata (rq_rdata),
        .empty (empty)
    );

    assign rq_head = result_t'(rq_rdata);
    assign status  = rq_head.status;
    assign out_x   = rq_head.out_x;
    assign out_y   = rq_head.out_y;

endmodule
